FILE: rtl/rsenc_pkg.sv
package rsenc_pkg;

    localparam int SYM_W = 8;
    localparam logic [SYM_W:0] FIELD_POLY = 9'h11D;
    localparam logic [SYM_W-1:0] CODE_LEN = 8'd255;
    localparam logic [SYM_W-1:0] DEF_MSG_LEN = 8'd223;
    localparam int DEF_MAX_PARITY = 32;

    typedef struct packed {
        logic             init;
        logic             build;
        logic             absorb;
        logic             last;
        logic             unload;
        logic [SYM_W-1:0] root;
        logic [SYM_W-1:0] data;
        logic [SYM_W-1:0] top;
    } t_cell_ctl;

    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b);
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] aa;
        acc = '0;
        aa  = a;
        for (int i = 0; i < SYM_W; i++) begin
            if (b[i]) begin
                acc = acc ^ aa;
            end
            aa = {aa[SYM_W-2:0], 1'b0} ^ (aa[SYM_W-1] ? FIELD_POLY[SYM_W-1:0] : '0);
        end
        return acc;
    endfunction

endpackage

FILE: rtl/rsenc_cell.sv
module rsenc_cell (
    input  logic                           i_clk,
    input  rsenc_pkg::t_cell_ctl           i_ctl,
    input  logic [rsenc_pkg::SYM_W-1:0]    i_init_g,
    input  logic [rsenc_pkg::SYM_W-1:0]    i_g_prev,
    input  logic [rsenc_pkg::SYM_W-1:0]    i_p_prev,
    input  logic [rsenc_pkg::SYM_W-1:0]    i_r_prev,
    output logic [rsenc_pkg::SYM_W-1:0]    o_g,
    output logic [rsenc_pkg::SYM_W-1:0]    o_p,
    output logic [rsenc_pkg::SYM_W-1:0]    o_r
);

    logic [rsenc_pkg::SYM_W-1:0] r_g, r_p, r_r;
    logic [rsenc_pkg::SYM_W-1:0] n_g, n_p, n_r;

    always_comb begin
        n_g = r_g;
        n_p = r_p;
        n_r = r_r;
        if (i_ctl.init) begin
            n_g = i_init_g;
            n_p = '0;
            n_r = '0;
        end else if (i_ctl.build) begin
            // multiply generator by (x + root)
            n_g = i_g_prev ^ rsenc_pkg::gf_mul(r_g, i_ctl.root);
            n_p = n_g;
            n_r = '0;
        end else if (i_ctl.absorb) begin
            n_r = r_r ^ rsenc_pkg::gf_mul(i_ctl.data, r_p);
            n_p = i_ctl.last ? r_g : (i_p_prev ^ rsenc_pkg::gf_mul(i_ctl.top, r_g));
        end else if (i_ctl.unload) begin
            n_r = i_r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g <= n_g;
        r_p <= n_p;
        r_r <= n_r;
    end

    assign o_g = r_g;
    assign o_p = r_p;
    assign o_r = r_r;

endmodule

FILE: rtl/reed_solomon_systematic_encoder_core.sv
// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11D.
// Input channel (i_valid/o_ready) takes one message symbol per transaction,
// lowest-degree coefficient first; k = message_length symbols make a codeword.
// Output channel (o_valid/i_ready) returns each message symbol, registered, in the
// cycle after it is taken, then after the k-th symbol the 255-k parity symbols, highest
// degree first, the last one marked by o_end_of_codeword.
// Message symbols sustain one per cycle while the output register is free; the parity
// burst holds the input until the last parity symbol has left the cell row, one symbol
// per cycle while the receiver is ready.
// Each cell of the row holds one remainder, residue and generator coefficient
// and is updated, partly from its lower neighbor, while building, absorbing or unloading.
// After reset, or a write to message_length, the generator for 255-k parity
// symbols (32 after reset) is rebuilt in the cell row with o_ready low; a write drops
// any codeword in progress. Out-of-range lengths are clamped to the supported
// parity range.
// A stalled receiver holds the output register; the input is taken only when
// that register is empty or being emptied in the same cycle.
module reed_solomon_systematic_encoder_core #(
    parameter int MAX_PARITY = rsenc_pkg::DEF_MAX_PARITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [rsenc_pkg::SYM_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rsenc_pkg::SYM_W-1:0] i_data_symbol,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rsenc_pkg::SYM_W-1:0] o_code_symbol,
    output logic                        o_is_parity,
    output logic                        o_end_of_codeword
);

    localparam int SW = rsenc_pkg::SYM_W;
    localparam int IDXW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int CNTW = $clog2(MAX_PARITY + 1);
    localparam logic [SW-1:0] KMIN = SW'(int'(rsenc_pkg::CODE_LEN) - MAX_PARITY);
    localparam logic [SW-1:0] KMAX = rsenc_pkg::CODE_LEN - SW'(1);

    localparam logic [1:0] ST_BUILD = 2'd0;
    localparam logic [1:0] ST_MSG   = 2'd1;
    localparam logic [1:0] ST_PAR   = 2'd2;

    function automatic logic [SW-1:0] clamp_k(input logic [SW-1:0] k);
        if (k < KMIN) begin
            return KMIN;
        end else if (k > KMAX) begin
            return KMAX;
        end
        return k;
    endfunction

    logic [1:0]      r_state;
    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_root;
    logic [SW-1:0]   r_k;
    logic [IDXW-1:0] r_nsym_m1;
    logic [SW-1:0]   r_sym_cnt;
    logic            r_ovalid;
    logic [SW-1:0]   r_code;
    logic            r_par;
    logic            r_eoc;

    logic [SW-1:0]   w_k_new;
    logic [SW-1:0]   w_nsym_new;
    logic            w_out_free;
    logic            w_acc;
    logic            w_last;
    logic            w_unload;
    rsenc_pkg::t_cell_ctl w_ctl;

    logic [SW-1:0] w_g [MAX_PARITY];
    logic [SW-1:0] w_p [MAX_PARITY];
    logic [SW-1:0] w_r [MAX_PARITY];

    assign w_k_new    = clamp_k(i_rst_n ? i_cfg_wr_data : rsenc_pkg::DEF_MSG_LEN);
    assign w_nsym_new = rsenc_pkg::CODE_LEN - w_k_new;
    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready    = (r_state == ST_MSG) && w_out_free;
    assign w_acc      = i_valid && o_ready;
    assign w_last     = (r_sym_cnt == (r_k - SW'(1)));
    assign w_unload   = (r_state == ST_PAR) && w_out_free;

    always_comb begin
        w_ctl.init   = !i_rst_n || i_cfg_wr_en;
        w_ctl.build  = (r_state == ST_BUILD);
        w_ctl.absorb = w_acc;
        w_ctl.last   = w_acc && w_last;
        w_ctl.unload = w_unload;
        w_ctl.root   = r_root;
        w_ctl.data   = i_data_symbol;
        w_ctl.top    = w_p[r_nsym_m1];
    end

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        rsenc_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_init_g ((j == 0) ? SW'(1) : SW'(0)),
            .i_g_prev ((j == 0) ? SW'(0) : w_g[(j == 0) ? 0 : j - 1]),
            .i_p_prev ((j == 0) ? SW'(0) : w_p[(j == 0) ? 0 : j - 1]),
            .i_r_prev ((j == 0) ? SW'(0) : w_r[(j == 0) ? 0 : j - 1]),
            .o_g      (w_g[j]),
            .o_p      (w_p[j]),
            .o_r      (w_r[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_state   <= ST_BUILD;
            r_cnt     <= CNTW'(w_nsym_new);
            r_root    <= SW'(1);
            r_k       <= w_k_new;
            r_nsym_m1 <= IDXW'(w_nsym_new - SW'(1));
            r_sym_cnt <= '0;
            if (!i_rst_n) begin
                r_ovalid <= 1'b0;
            end
        end else begin
            unique case (r_state)
                ST_BUILD: begin
                    r_root <= rsenc_pkg::gf_mul(r_root, SW'(2));
                    r_cnt  <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= ST_MSG;
                    end
                end
                ST_MSG: begin
                    if (w_acc) begin
                        if (w_last) begin
                            r_sym_cnt <= '0;
                            r_state   <= ST_PAR;
                            r_cnt     <= CNTW'(r_nsym_m1) + CNTW'(1);
                        end else begin
                            r_sym_cnt <= r_sym_cnt + SW'(1);
                        end
                    end
                end
                ST_PAR: begin
                    if (w_out_free) begin
                        r_cnt <= r_cnt - CNTW'(1);
                        if (r_cnt == CNTW'(1)) begin
                            r_state <= ST_MSG;
                        end
                    end
                end
                default: begin
                    r_state <= ST_MSG;
                end
            endcase
        end

        if (i_rst_n) begin
            if (w_acc) begin
                r_ovalid <= 1'b1;
                r_code   <= i_data_symbol;
                r_par    <= 1'b0;
                r_eoc    <= 1'b0;
            end else if (w_unload && !i_cfg_wr_en) begin
                r_ovalid <= 1'b1;
                r_code   <= w_r[r_nsym_m1];
                r_par    <= 1'b1;
                r_eoc    <= (r_cnt == CNTW'(1));
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_code_symbol     = r_code;
    assign o_is_parity       = r_par;
    assign o_end_of_codeword = r_eoc;

    a_last_to_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last && !i_cfg_wr_en) |=> (r_state == ST_PAR))
        else $error("last message symbol did not start parity");

    a_eoc_is_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_codeword) |-> o_is_parity)
        else $error("end of codeword on a message symbol");

    a_par_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_unload && (r_cnt == CNTW'(1)) && !i_cfg_wr_en)
            |=> ((r_state == ST_MSG) && o_end_of_codeword && o_valid))
        else $error("parity burst ended without end of codeword");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MSG) |-> (r_cnt != '0))
        else $error("build or parity count ran out");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAR && r_ovalid && !i_ready && !i_cfg_wr_en)
            |=> ($stable(r_cnt) && $stable(r_code)))
        else $error("parity advanced while receiver stalled");

endmodule

FILE: sim/reed_solomon_systematic_encoder_core_tb.sv
`timescale 1ns / 1ps

module reed_solomon_systematic_encoder_core_tb;

    localparam int SYM_W = rsenc_pkg::SYM_W;
    localparam int MAXP = rsenc_pkg::DEF_MAX_PARITY;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 430;

    typedef struct packed {
        logic [SYM_W-1:0] code;
        logic             parity;
        logic             eoc;
    } t_code_entry;

    class rs_codeword_tracker;
        int unsigned      k_eff;
        int unsigned      nsym;
        int unsigned      count;
        logic [SYM_W-1:0] gen[MAXP];
        logic [SYM_W-1:0] rem[MAXP];
        logic [SYM_W-1:0] res[MAXP];
        t_code_entry      pending[$];
        int               errors;

        function new();
            errors = 0;
            set_length(rsenc_pkg::DEF_MSG_LEN);
        endfunction

        function logic [SYM_W-1:0] gf_times(logic [SYM_W-1:0] a,
                                            logic [SYM_W-1:0] b);
            logic [SYM_W-1:0] p;
            logic [SYM_W:0]   x;
            p = '0;
            x = {1'b0, a};
            for (int i = 0; i < SYM_W; i++) begin
                if (b[i]) begin
                    p = p ^ x[SYM_W-1:0];
                end
                x = x << 1;
                if (x[SYM_W]) begin
                    x = x ^ rsenc_pkg::FIELD_POLY;
                end
            end
            return p;
        endfunction

        function void restart();
            count = 0;
            for (int j = 0; j < MAXP; j++) begin
                rem[j] = '0;
                res[j] = gen[j];
            end
        endfunction

        function void set_length(logic [SYM_W-1:0] v);
            logic [SYM_W-1:0] poly[MAXP+1];
            logic [SYM_W-1:0] root;
            int               k;
            k = int'(v);
            if (k < 255 - MAXP) begin
                k = 255 - MAXP;
            end
            if (k > 254) begin
                k = 254;
            end
            k_eff = k;
            nsym = 255 - k;
            for (int j = 0; j <= MAXP; j++) begin
                poly[j] = '0;
            end
            poly[0] = 8'd1;
            root = 8'd1;
            for (int i = 0; i < nsym; i++) begin
                for (int j = i + 1; j >= 1; j--) begin
                    poly[j] = poly[j-1] ^ gf_times(poly[j], root);
                end
                poly[0] = gf_times(poly[0], root);
                root = gf_times(root, 8'd2);
            end
            for (int j = 0; j < MAXP; j++) begin
                gen[j] = (j < nsym) ? poly[j] : '0;
            end
            restart();
        endfunction

        // one accepted message symbol: echo plus parity burst at the end
        function void absorb_symbol(logic [SYM_W-1:0] d);
            logic [SYM_W-1:0] top;
            pending.push_back('{code: d, parity: 1'b0, eoc: 1'b0});
            for (int j = 0; j < nsym; j++) begin
                rem[j] = rem[j] ^ gf_times(d, res[j]);
            end
            top = res[nsym-1];
            for (int j = nsym - 1; j >= 1; j--) begin
                res[j] = res[j-1] ^ gf_times(top, gen[j]);
            end
            res[0] = gf_times(top, gen[0]);
            count = (count + 1) & 8'hFF;
            if (count >= k_eff) begin
                for (int j = nsym; j >= 1; j--) begin
                    pending.push_back('{code: rem[j-1], parity: 1'b1, eoc: (j == 1)});
                end
                restart();
            end
        endfunction

        function void check_symbol(logic [SYM_W-1:0] code, logic parity, logic eoc);
            t_code_entry e;
            if (pending.size() == 0) begin
                $error("unexpected output transaction: code_symbol %0h", code);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (code !== e.code) begin
                $error("code_symbol: expected %0h, actual %0h", e.code, code);
                errors++;
            end
            if (parity !== e.parity) begin
                $error("is_parity: expected %0b, actual %0b", e.parity, parity);
                errors++;
            end
            if (eoc !== e.eoc) begin
                $error("end_of_codeword: expected %0b, actual %0b", e.eoc, eoc);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [SYM_W-1:0] i_cfg_wr_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [SYM_W-1:0] i_data_symbol = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [SYM_W-1:0] o_code_symbol;
    logic             o_is_parity;
    logic             o_end_of_codeword;

    rs_codeword_tracker tracker;
    bit                 jitter_en = 1'b1;
    bit                 rx_hold_req = 1'b0;

    reed_solomon_systematic_encoder_core #(
        .MAX_PARITY(MAXP)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_symbol    (i_data_symbol),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_code_symbol    (o_code_symbol),
        .o_is_parity      (o_is_parity),
        .o_end_of_codeword(o_end_of_codeword)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!jitter_en || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_symbol(input logic [SYM_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_symbol <= d;
        do @(posedge i_clk); while (!o_ready);
        tracker.absorb_symbol(d);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [SYM_W-1:0] v);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_length(v);
    endtask

    // output side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_symbol(o_code_symbol, o_is_parity, o_end_of_codeword);
        end
    end

    initial begin : receiver
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (jitter_en && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [SYM_W-1:0] directed[$];
        int               random_items;
        int               phase;
        int               n;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes at the reset length, then writes that drop a partial codeword
        directed = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        foreach (directed[i]) begin
            send_symbol(directed[i]);
        end
        write_length(8'd255);
        send_symbol(8'hFE);
        send_symbol(8'h7F);
        send_symbol(8'h02);
        write_length(8'd0);
        send_symbol(8'hFF);
        send_symbol(8'h00);
        send_symbol(8'h40);
        write_length(8'd254);
        send_symbol(8'h01);
        send_symbol(8'hFF);
        send_symbol(8'h20);
        write_length(8'd100);
        send_symbol(8'hC3);
        send_symbol(8'h3C);
        write_length(8'd222);
        send_symbol(8'h10);
        send_symbol(8'hEF);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                write_length(8'd254);
            end else if (phase == 1) begin
                write_length(rsenc_pkg::DEF_MSG_LEN);
            end else if ($urandom_range(0, 3) == 0) begin
                write_length(SYM_W'($urandom_range(0, 255)));
            end else begin
                write_length(SYM_W'($urandom_range(223, 254)));
            end
            n = tracker.k_eff;
            for (int i = 0; i < n; i++) begin
                if (phase == 0 && i == 10) begin
                    rx_hold_req = 1'b1;
                end
                if ($urandom_range(0, 39) == 0) begin
                    jitter_en = !jitter_en;
                end
                send_symbol(SYM_W'($urandom_range(0, 255)));
                random_items++;
            end
            // broken sequence, dropped by the next length write
            if ($urandom_range(0, 1) == 0) begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++) begin
                    send_symbol(SYM_W'($urandom_range(0, 255)));
                    random_items++;
                end
            end
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rsenc_pkg.sv
rtl/rsenc_cell.sv
rtl/reed_solomon_systematic_encoder_core.sv
sim/reed_solomon_systematic_encoder_core_tb.sv
